[rtl/heater_onoff_with_run_pause_timers_macros.svh]
// Assertion helpers for the heater controller
`ifndef HEATER_ONOFF_WITH_RUN_PAUSE_TIMERS_MACROS_SVH
`define HEATER_ONOFF_WITH_RUN_PAUSE_TIMERS_MACROS_SVH

// same-cycle implication
`define HOR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heater controller check failed");

// next-cycle implication
`define HOR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heater controller check failed");

`endif

[rtl/hor_pkg.sv]
package hor_pkg;

    localparam int ZONES        = 8;
    localparam int ZIDX_W       = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int CFG_W        = 15;
    localparam int CNT_W        = 9;
    localparam int TEMP_W       = 16;
    localparam int MINUTE_UNITS = 100;
    // x / 100 == (x * 5243) >> 19 for every 15-bit x
    localparam int RECIP_100    = 5243;
    localparam int RECIP_SHIFT  = 19;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef enum logic [2:0] {
        CFG_ON_DELTA  = 3'd0,
        CFG_OFF_DELTA = 3'd1,
        CFG_MIN_RUN   = 3'd2,
        CFG_MAX_RUN   = 3'd3,
        CFG_PAUSE     = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_TICK
    } t_state;

    typedef struct packed {
        logic              capture;
        logic              eval_en;
        logic              tick_en;
        logic [ZIDX_W-1:0] tick_zone;
    } t_ctl_cmd;

    typedef struct packed {
        logic skip;
        logic out_free;
    } t_dp_sts;

    function automatic logic [CNT_W-1:0] div_minutes(input logic [CFG_W-1:0] x);
        logic [27:0] p;
        p = 28'(x) * 28'(RECIP_100);
        return p[RECIP_SHIFT +: CNT_W];
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

[rtl/hor_ctrl.sv]
module hor_ctrl
    import hor_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_command,
    output logic     o_ready,
    input  t_dp_sts  i_sts,
    output t_ctl_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [ZIDX_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        o_ready         = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.eval_en   = 1'b0;
        o_cmd.tick_en   = 1'b0;
        o_cmd.tick_zone = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_cnt   = '0;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = (i_command == CMD_EVAL) ? S_EVAL : S_TICK;
                end
            end
            S_EVAL: begin
                if (i_sts.skip) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.eval_en = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_TICK: begin
                o_cmd.tick_en = 1'b1;
                if (r_cnt == ZIDX_W'(ZONES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[rtl/hor_dp.sv]
module hor_dp
    import hor_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic [2:0]               i_zone,
    input  logic signed [TEMP_W-1:0] i_measured_temp,
    input  logic signed [TEMP_W-1:0] i_target_temp,
    input  logic                     i_manual_mode,
    input  t_ctl_cmd                 i_cmd,
    output t_dp_sts                  o_sts,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2:0]               o_out_zone,
    output logic                     o_heater_on,
    output logic [CFG_W-1:0]         o_run_time_report
);

    logic [CFG_W-1:0] r_on_delta, r_off_delta;
    logic [CNT_W-1:0] r_min_q, r_max_q, r_pause_q;

    logic [2:0]               r_zone;
    logic signed [TEMP_W-1:0] r_meas, r_targ;
    logic                     r_manual;

    logic             r_on    [ZONES];
    logic [CNT_W-1:0] r_run   [ZONES];
    logic [CNT_W-1:0] r_pause [ZONES];

    logic             r_out_valid;
    logic [2:0]       r_out_zone;
    logic             r_out_on;
    logic [CFG_W-1:0] r_out_rpt;

    logic [ZIDX_W-1:0]      sel;
    logic                   c_on;
    logic [CNT_W-1:0]       c_run, c_pause;
    logic signed [TEMP_W:0] meas_x, targ_x;
    logic [TEMP_W:0]        deficit, excess;
    logic                   pos, on_hit, off_hit;
    logic                   e_on, t_on, w_on;
    logic [CNT_W-1:0]       e_run, e_pause, t_run, t_pause, w_run, w_pause;
    logic [15:0]            rpt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_delta  <= '0;
            r_off_delta <= '0;
            r_min_q     <= '0;
            r_max_q     <= '0;
            r_pause_q   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ON_DELTA:  r_on_delta  <= i_cfg_data;
                CFG_OFF_DELTA: r_off_delta <= i_cfg_data;
                CFG_MIN_RUN:   r_min_q     <= div_minutes(i_cfg_data);
                CFG_MAX_RUN:   r_max_q     <= div_minutes(i_cfg_data);
                CFG_PAUSE:     r_pause_q   <= div_minutes(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_zone   <= i_zone;
            r_meas   <= i_measured_temp;
            r_targ   <= i_target_temp;
            r_manual <= i_manual_mode;
        end
    end

    assign o_sts.skip     = r_manual || (int'(r_zone) >= ZONES);
    assign o_sts.out_free = !r_out_valid || i_ready;

    assign sel     = i_cmd.tick_en ? i_cmd.tick_zone : ZIDX_W'(r_zone);
    assign c_on    = r_on[sel];
    assign c_run   = r_run[sel];
    assign c_pause = r_pause[sel];

    // evaluate
    always_comb begin
        meas_x  = (TEMP_W+1)'(r_meas);
        targ_x  = (TEMP_W+1)'(r_targ);
        deficit = '0;
        excess  = '0;
        if (r_meas < r_targ) begin
            deficit = unsigned'(targ_x - meas_x);
        end else begin
            excess = unsigned'(meas_x - targ_x);
        end
        pos     = !r_meas[TEMP_W-1] && (r_meas != '0);
        on_hit  = ((TEMP_W+1)'(r_on_delta) <= deficit) && (c_pause == '0);
        off_hit = ((TEMP_W+1)'(r_off_delta) <= excess) && (c_run >= r_min_q);
        e_on    = c_on;
        e_run   = c_run;
        e_pause = c_pause;
        if (pos) begin
            if (on_hit) begin
                e_on    = 1'b1;
                e_pause = bump(c_pause);
            end
            if (off_hit) begin
                e_on    = 1'b0;
                e_run   = '0;
                e_pause = CNT_W'(1);
            end
        end
        rpt = 16'({e_run, 6'b0}) + 16'({e_run, 5'b0}) + 16'({e_run, 2'b0});
    end

    // one-minute tick
    always_comb begin
        t_on    = c_on;
        t_run   = c_run;
        t_pause = c_pause;
        if (c_on) begin
            if (c_run >= r_max_q) begin
                t_on    = 1'b0;
                t_run   = '0;
                t_pause = CNT_W'(1);
            end else begin
                t_run = bump(c_run);
            end
        end
        if (!t_on) begin
            if (t_pause >= r_pause_q) begin
                t_pause = '0;
            end else if (t_pause != '0) begin
                t_pause = bump(t_pause);
            end
        end
    end

    assign w_on    = i_cmd.tick_en ? t_on    : e_on;
    assign w_run   = i_cmd.tick_en ? t_run   : e_run;
    assign w_pause = i_cmd.tick_en ? t_pause : e_pause;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int z = 0; z < ZONES; z++) begin
                r_on[z]    <= 1'b0;
                r_run[z]   <= '0;
                r_pause[z] <= CNT_W'(1);
            end
        end else if (i_cmd.tick_en || i_cmd.eval_en) begin
            r_on[sel]    <= w_on;
            r_run[sel]   <= w_run;
            r_pause[sel] <= w_pause;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.eval_en) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_en) begin
            r_out_zone <= r_zone;
            r_out_on   <= e_on;
            r_out_rpt  <= rpt[CFG_W-1:0];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_out_zone        = r_out_zone;
    assign o_heater_on       = r_out_on;
    assign o_run_time_report = r_out_rpt;

endmodule

[rtl/heater_onoff_with_run_pause_timers.sv]
// On/off heater controller for eight zones with run and re-enable pause timers.
// Input channel (i_valid/o_ready): i_command 0 is a one-minute tick for all
// zones, 1 evaluates zone i_zone against i_measured_temp and i_target_temp.
// An evaluate with i_manual_mode set, and every tick, returns no item.
// Output channel (o_valid/i_ready): one item per evaluation, zone, heater state
// and run minutes times 100, held in an output register.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index (0 on_delta,
// 1 off_delta, 2 min run, 3 max run, 4 pause); write only while idle.
// Timing: an evaluate is accepted in S_IDLE and, once the output register is free,
// written to it from S_EVAL, which raises o_valid; a tick sweeps the zone state
// one zone per cycle in S_TICK, then the block is ready again. No new item is
// taken before S_IDLE, set by the single read/write port on the per-zone state.
// The next item is taken while a result still waits in the output register;
// an evaluate then waits until that result is taken.
// Reset (synchronous, active low): all zones off, run 0, pause 1, registers 0,
// output empty.
`include "heater_onoff_with_run_pause_timers_macros.svh"

module heater_onoff_with_run_pause_timers
    import hor_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_command,
    input  logic [2:0]               i_zone,
    input  logic signed [TEMP_W-1:0] i_measured_temp,
    input  logic signed [TEMP_W-1:0] i_target_temp,
    input  logic                     i_manual_mode,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [2:0]               o_out_zone,
    output logic                     o_heater_on,
    output logic [CFG_W-1:0]         o_run_time_report
);

    t_ctl_cmd cmd;
    t_dp_sts  sts;

    hor_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_ready   (o_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    hor_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_zone            (i_zone),
        .i_measured_temp   (i_measured_temp),
        .i_target_temp     (i_target_temp),
        .i_manual_mode     (i_manual_mode),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_out_zone        (o_out_zone),
        .o_heater_on       (o_heater_on),
        .o_run_time_report (o_run_time_report)
    );

    `HOR_ASSERT_NOW(a_no_overwrite, cmd.eval_en, !o_valid || i_ready)
    `HOR_ASSERT_NEXT(a_busy_after_accept, cmd.capture, !o_ready)
    `HOR_ASSERT_NOW(a_out_from_eval, $rose(o_valid), $past(cmd.eval_en))

endmodule
